// ===== rtl/string_hash_partitioner_assert.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef STRING_HASH_PARTITIONER_ASSERT_SVH
`define STRING_HASH_PARTITIONER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/shp_pkg.sv =====
`timescale 1ns / 1ps
package shp_pkg;

    localparam int HASH_W     = 64;
    localparam int BYTE_W     = 8;
    localparam int NPART_W    = 16;
    localparam int CNT_W      = $clog2(HASH_W);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [HASH_W-1:0]  HASH_SEED   = HASH_W'(5381);
    localparam logic [NPART_W-1:0] NPART_RESET = NPART_W'(1);

    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic              byte_valid;
        logic              key_end;
    } t_in_item;

    typedef struct packed {
        logic [NPART_W-1:0] partition_index;
        logic [HASH_W-1:0]  hash_value;
    } t_out_item;

endpackage

// ===== rtl/shp_front.sv =====
`timescale 1ns / 1ps
module shp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  shp_pkg::t_in_item          i_item,
    output logic                       o_q_push,
    output logic [shp_pkg::HASH_W-1:0] o_q_data
);

    logic [shp_pkg::HASH_W-1:0] r_hash;
    logic [shp_pkg::HASH_W-1:0] n_hash;
    logic [shp_pkg::HASH_W-1:0] w_byte_ext;
    logic [shp_pkg::HASH_W-1:0] w_hashed;

    // The byte is sign-extended; multiplying by 33 is a shift by five plus the value.
    assign w_byte_ext = {{(shp_pkg::HASH_W-shp_pkg::BYTE_W){i_item.key_byte[shp_pkg::BYTE_W-1]}},
                         i_item.key_byte};
    assign w_hashed   = i_item.byte_valid ? ((r_hash << 5) + r_hash + w_byte_ext) : r_hash;

    assign o_q_push = i_accept && i_item.key_end;
    assign o_q_data = w_hashed;

    always_comb begin
        n_hash = r_hash;
        if (i_accept) begin
            n_hash = i_item.key_end ? shp_pkg::HASH_SEED : w_hashed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= shp_pkg::HASH_SEED;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

// ===== rtl/shp_fifo.sv =====
`timescale 1ns / 1ps
module shp_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [shp_pkg::HASH_W-1:0] i_wr_data,
    input  logic                       i_pop,
    output logic [shp_pkg::HASH_W-1:0] o_rd_data,
    output logic                       o_full,
    output logic                       o_empty
);

    logic [shp_pkg::HASH_W-1:0] r_mem [shp_pkg::FIFO_DEPTH];
    logic [shp_pkg::PTR_W-1:0]  r_wr_ptr;
    logic [shp_pkg::PTR_W-1:0]  r_rd_ptr;
    logic [shp_pkg::PTR_W:0]    r_count;
    logic                       w_do_push;
    logic                       w_do_pop;

    assign o_full    = (r_count == (shp_pkg::PTR_W+1)'(shp_pkg::FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/shp_mod.sv =====
`timescale 1ns / 1ps
module shp_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [shp_pkg::NPART_W-1:0] i_num_partitions,
    input  logic                        i_q_empty,
    input  logic [shp_pkg::HASH_W-1:0]  i_q_data,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output shp_pkg::t_out_item          o_item
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_back_state;

    t_back_state                 r_state;
    t_back_state                 n_state;
    logic [shp_pkg::CNT_W-1:0]   r_cnt;
    logic [shp_pkg::HASH_W-1:0]  r_dividend;
    logic [shp_pkg::NPART_W-1:0] r_rem;
    shp_pkg::t_out_item          r_res;
    logic [shp_pkg::NPART_W:0]   w_trial;
    logic [shp_pkg::NPART_W-1:0] w_diff;
    logic                        w_ge;
    logic [shp_pkg::NPART_W-1:0] w_rem_next;
    logic [shp_pkg::HASH_W-1:0]  w_rot;
    logic                        w_last;

    // One remainder bit per cycle, most significant dividend bit first. The
    // dividend rotates, so after the last step it holds the hash again.
    // When the trial value is not below the divisor, the difference fits in
    // the low bits, so the subtraction only needs those.
    assign w_trial    = {r_rem, r_dividend[shp_pkg::HASH_W-1]};
    assign w_diff     = w_trial[shp_pkg::NPART_W-1:0] - i_num_partitions;
    assign w_ge       = (w_trial >= {1'b0, i_num_partitions});
    assign w_rem_next = w_ge ? w_diff : w_trial[shp_pkg::NPART_W-1:0];
    assign w_rot      = {r_dividend[shp_pkg::HASH_W-2:0], r_dividend[shp_pkg::HASH_W-1]};
    assign w_last     = (r_cnt == shp_pkg::CNT_W'(shp_pkg::HASH_W-1));

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty = (r_state != S_DONE);
    assign o_item  = r_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_pop) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_dividend <= i_q_data;
            r_rem      <= '0;
        end else if (r_state == S_DIV) begin
            r_dividend <= w_rot;
            r_rem      <= w_rem_next;
        end
        if ((r_state == S_DIV) && w_last) begin
            r_res.hash_value      <= w_rot;
            // A zero divisor gives partition zero.
            r_res.partition_index <= (i_num_partitions == '0) ? '0 : w_rem_next;
        end
    end

endmodule

// ===== rtl/string_hash_partitioner.sv =====
// Key bytes are accepted one per cycle while the four-entry key queue has room.
// The transaction that ends a key pushes its hash into the queue; the result appears once the
// back end has taken it from the queue and run it through its one-bit-per-cycle remainder unit.
// The back end takes no new key from the queue until its result has been popped.
// Reset is synchronous and active low: the hash returns to 5381, the divisor to 1,
// and the queue and result register empty. There is no clearing pass.
`timescale 1ns / 1ps
`include "string_hash_partitioner_assert.svh"
module string_hash_partitioner (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  shp_pkg::t_in_item           i_in_item,
    output logic                        empty,
    input  logic                        pop,
    output shp_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_we,
    input  logic [shp_pkg::NPART_W-1:0] i_cfg_wdata
);

    logic [shp_pkg::NPART_W-1:0] r_npart;
    logic                        w_accept;
    logic                        w_q_push;
    logic [shp_pkg::HASH_W-1:0]  w_q_wdata;
    logic [shp_pkg::HASH_W-1:0]  w_q_rdata;
    logic                        w_q_pop;
    logic                        w_q_full;
    logic                        w_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_npart <= shp_pkg::NPART_RESET;
        end else if (i_cfg_we) begin
            r_npart <= i_cfg_wdata;
        end
    end

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    shp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_q_push (w_q_push),
        .o_q_data (w_q_wdata)
    );

    shp_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_q_push),
        .i_wr_data (w_q_wdata),
        .i_pop     (w_q_pop),
        .o_rd_data (w_q_rdata),
        .o_full    (w_q_full),
        .o_empty   (w_q_empty)
    );

    shp_mod u_mod (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_num_partitions (r_npart),
        .i_q_empty        (w_q_empty),
        .i_q_data         (w_q_rdata),
        .o_q_pop          (w_q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_item           (o_out_item)
    );

    `SHP_ASSERT(a_no_queue_overflow, i_clk, i_rst_n, !(w_q_push && w_q_full), "key queue overflow")
    `SHP_ASSERT(a_index_in_range, i_clk, i_rst_n, empty || (r_npart == '0) || (o_out_item.partition_index < r_npart), "partition index out of range")
    `SHP_ASSERT_NEXT(a_pop_clears, i_clk, i_rst_n, pop && !empty, empty, "result still shown after pop")
    `SHP_ASSERT(a_no_pop_while_busy, i_clk, i_rst_n, !(w_q_pop && !empty), "queue read while a result waits")

endmodule
